// File: design/field_escape_codec_top_macros.svh
// Assertion macros shared by the checker
`ifndef FIELD_ESCAPE_CODEC_TOP_MACROS_SVH
`define FIELD_ESCAPE_CODEC_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define FEC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define FEC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define FEC_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/fec_pkg.sv
package fec_pkg;

    localparam int unsigned FEC_JOB_DEPTH = 2;

    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_BAR  = 8'h7C;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_DIG0 = 8'h30;
    localparam logic [7:0] CH_DIG2 = 8'h32;
    localparam logic [7:0] CH_DIG5 = 8'h35;
    localparam logic [7:0] CH_DIG7 = 8'h37;
    localparam logic [7:0] CH_UPA  = 8'h41;
    localparam logic [7:0] CH_UPC  = 8'h43;
    localparam logic [7:0] CH_UPD  = 8'h44;

    localparam logic [4:0] HEX_NONE = 5'd16;

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_PCT   = 2'd1;
    localparam logic [1:0] PEND_DIGIT = 2'd2;

    localparam logic [1:0] CNT_NONE  = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       field_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_field_end;
        logic       run_last;
    } t_out_item;

    // up to three output bytes produced by one input byte, oldest in bytes[0]
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            fe;
    } t_job;

    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] r;
        r = HEX_NONE;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b0, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r = {1'b0, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    function automatic logic is_special(input logic [7:0] v);
        return (v == CH_PCT) || (v == CH_BAR) || (v == CH_CR) || (v == CH_LF);
    endfunction

    function automatic logic [7:0] enc_hi(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            CH_PCT:  r = CH_DIG2;
            CH_BAR:  r = CH_DIG7;
            default: r = CH_DIG0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] enc_lo(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            CH_PCT:  r = CH_DIG5;
            CH_BAR:  r = CH_UPC;
            CH_CR:   r = CH_UPD;
            default: r = CH_UPA;
        endcase
        return r;
    endfunction

endpackage

// File: design/fec_front.sv
module fec_front import fec_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_decode_mode,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_job     o_job
);

    logic       r_mode;
    logic [1:0] r_pend;
    logic [1:0] n_pend;
    logic [7:0] r_held;
    logic [7:0] n_held;
    logic [7:0] b;
    logic       fe;
    logic [4:0] hv;
    logic [4:0] lv;
    logic [7:0] v;
    logic       esc_ok;
    t_job       job;

    assign b      = i_item.in_byte;
    assign fe     = i_item.field_end;
    assign hv     = hex_of(r_held);
    assign lv     = hex_of(b);
    assign v      = {hv[3:0], lv[3:0]};
    assign esc_ok = !hv[4] && !lv[4] && is_special(v);

    always_comb begin
        n_pend = r_pend;
        n_held = r_held;
        job    = '0;
        job.fe = fe;
        if (!r_mode) begin
            if (is_special(b)) begin
                job.bytes[0] = CH_PCT;
                job.bytes[1] = enc_hi(b);
                job.bytes[2] = enc_lo(b);
                job.cnt      = CNT_THREE;
            end else begin
                job.bytes[0] = b;
                job.cnt      = CNT_ONE;
            end
        end else begin
            case (r_pend)
                PEND_PCT: begin
                    if (fe) begin
                        job.bytes[0] = CH_PCT;
                        job.bytes[1] = b;
                        job.cnt      = CNT_TWO;
                    end else begin
                        n_held = b;
                        n_pend = PEND_DIGIT;
                    end
                end
                PEND_DIGIT: begin
                    if (esc_ok) begin
                        job.bytes[0] = v;
                        job.cnt      = CNT_ONE;
                        n_pend       = PEND_NONE;
                    end else if (r_held == CH_PCT) begin
                        // held '%' opens a new escape with this byte
                        job.bytes[0] = CH_PCT;
                        if (fe) begin
                            job.bytes[1] = CH_PCT;
                            job.bytes[2] = b;
                            job.cnt      = CNT_THREE;
                        end else begin
                            job.cnt = CNT_ONE;
                            n_held  = b;
                        end
                    end else begin
                        job.bytes[0] = CH_PCT;
                        job.bytes[1] = r_held;
                        if (b == CH_PCT && !fe) begin
                            job.cnt = CNT_TWO;
                            n_pend  = PEND_PCT;
                        end else begin
                            job.bytes[2] = b;
                            job.cnt      = CNT_THREE;
                            n_pend       = PEND_NONE;
                        end
                    end
                end
                default: begin
                    if (b == CH_PCT && !fe) begin
                        n_pend = PEND_PCT;
                    end else begin
                        job.bytes[0] = b;
                        job.cnt      = CNT_ONE;
                        n_pend       = PEND_NONE;
                    end
                end
            endcase
            if (fe) begin
                n_pend = PEND_NONE;
            end
        end
    end

    assign o_job = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_pend <= PEND_NONE;
            r_held <= '0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_decode_mode;
            r_pend <= PEND_NONE;
            r_held <= '0;
        end else if (i_accept) begin
            r_pend <= n_pend;
            r_held <= n_held;
        end
    end

endmodule

// File: design/fec_queue.sv
module fec_queue import fec_pkg::*; #(
    parameter int unsigned DEPTH = FEC_JOB_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : PW'(r_wr + 1'b1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : PW'(r_rd + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= CW'(r_cnt + 1'b1);
            end else if (do_pop && !do_push) begin
                r_cnt <= CW'(r_cnt - 1'b1);
            end
        end
    end

endmodule

// File: design/fec_back.sv
module fec_back import fec_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_head,
    input  logic      i_valid,
    input  logic      i_pop,
    output logic      o_deq,
    output t_out_item o_item
);

    logic [1:0] r_idx;
    logic       last;
    logic       xfer;

    assign last = (r_idx == 2'(i_head.cnt - CNT_ONE));
    assign xfer = i_valid && i_pop;
    assign o_deq = xfer && last;

    assign o_item.out_byte      = i_head.bytes[r_idx];
    assign o_item.run_last      = last;
    assign o_item.out_field_end = last && i_head.fe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (xfer) begin
            r_idx <= last ? '0 : 2'(r_idx + 1'b1);
        end
    end

endmodule

// File: design/field_escape_codec_top.sv
// Streaming percent-escape codec for the bytes of one text field. With decode_mode at 0 the
// bytes '%', '|', CR and LF become three-byte escapes and all others pass; with 1, such
// escapes (hex digits of either case) are restored and anything else passes raw. A '%' and
// the byte after it are held until the escape can be decided, so those transfers produce no
// result until a later byte arrives; a field end flushes everything held. A byte is taken
// every cycle while full is low; its results go into the job queue as one job and leave
// the output one result per cycle while pop is high, so throughput is set by the output
// side. A queue of JOB_DEPTH jobs sits between the classifying front and the output
// serializer. Write decode_mode only while the block is idle; a write drops any held bytes.
module field_escape_codec_top import fec_pkg::*; #(
    parameter int unsigned JOB_DEPTH = FEC_JOB_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic      i_cfg_decode_mode
);

    logic accept;
    logic q_push;
    logic q_pop;
    t_job job;
    t_job head;

    assign accept = push && !full;
    assign q_push = accept && (job.cnt != CNT_NONE);

    fec_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_decode_mode (i_cfg_decode_mode),
        .i_accept          (accept),
        .i_item            (i_in_item),
        .o_job             (job)
    );

    fec_queue #(
        .DEPTH (JOB_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (job),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    fec_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_valid (!empty),
        .i_pop   (pop),
        .o_deq   (q_pop),
        .o_item  (o_out_item)
    );

endmodule

// File: design/fec_checker.sv
`include "field_escape_codec_top_macros.svh"

module fec_checker import fec_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_out_item
);

    `FEC_ASSERT_RST(a_rst_empty, !i_rst_n, empty, "queue not empty after reset")
    `FEC_ASSERT_IMP(a_fe_last, o_out_item.out_field_end, o_out_item.run_last, "fe on non-last")
    `FEC_ASSERT_IMP(a_full_nonempty, full, !empty, "full while no result waits")
    `FEC_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(o_out_item), "waiting result changed")

endmodule

bind field_escape_codec_top fec_checker u_fec_checker (.*);

// File: tb/sv/field_escape_codec_top_test.sv
module field_escape_codec_top_test;
    import fec_pkg::*;

    localparam int IDLE_LIMIT  = 1000;
    localparam int PHASE_ITEMS = 13;
    // bit p is the mode of random phase p
    localparam logic [5:0] PHASE_MODES = 6'b110101;

    typedef struct packed {
        logic       mode;
        logic [7:0] b;
        logic       fe;
        logic [1:0] n_typed;
        logic [7:0] t0;
        logic [7:0] t1;
        logic [7:0] t2;
    } dir_row_t;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_in_item;
    logic      empty;
    logic      pop;
    t_out_item o_out_item;
    logic      i_cfg_we;
    logic      i_cfg_decode_mode;

    logic       cur_mode;
    logic [1:0] held_cnt;
    logic [7:0] held_byte;
    t_out_item  step_q[$];
    t_out_item  out_bytes_due[$];
    logic [7:0] field_bytes[$];

    int errors;
    int bytes_in;
    int results_out;
    int mode_writes;
    int full_cycles;
    int idle_cycles;
    bit tx_idle_on;
    bit rx_idle_on;
    bit long_stall_done;

    field_escape_codec_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_in_item        (i_in_item),
        .empty            (empty),
        .pop              (pop),
        .o_out_item       (o_out_item),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_decode_mode(i_cfg_decode_mode)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit is_esc(logic [7:0] v);
        return v == CH_PCT || v == CH_BAR || v == CH_CR || v == CH_LF;
    endfunction

    function automatic int hex_val(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'(CH_DIG0);
        if (c >= "A" && c <= "F") return int'(c) - int'(CH_UPA) + 10;
        if (c >= "a" && c <= "f") return int'(c) - 'h61 + 10;
        return 16;
    endfunction

    function automatic void put(logic [7:0] b);
        t_out_item r;
        r.out_byte      = b;
        r.out_field_end = 1'b0;
        r.run_last      = 1'b0;
        if (step_q.size() < 3) step_q.insert(step_q.size(), r);
    endfunction

    function automatic void after_pct(logic [7:0] b, logic fe);
        if (fe) begin
            put(CH_PCT);
            put(b);
            held_cnt = PEND_NONE;
        end else begin
            held_byte = b;
            held_cnt  = PEND_DIGIT;
        end
    endfunction

    function automatic void fresh(logic [7:0] b, logic fe);
        if (b == CH_PCT && !fe) begin
            held_cnt = PEND_PCT;
        end else begin
            put(b);
            held_cnt = PEND_NONE;
        end
    endfunction

    // results of one input byte into step_q, codec state advanced
    function automatic void codec_step(logic [7:0] b, logic fe);
        int         hi;
        int         lo;
        logic [7:0] v;
        t_out_item  r;
        step_q.delete();
        if (!cur_mode) begin
            if (is_esc(b)) begin
                put(CH_PCT);
                case (b)
                    CH_PCT: begin
                        put(CH_DIG2);
                        put(CH_DIG5);
                    end
                    CH_BAR: begin
                        put(CH_DIG7);
                        put(CH_UPC);
                    end
                    CH_CR: begin
                        put(CH_DIG0);
                        put(CH_UPD);
                    end
                    default: begin
                        put(CH_DIG0);
                        put(CH_UPA);
                    end
                endcase
            end else begin
                put(b);
            end
        end else begin
            case (held_cnt)
                PEND_PCT: after_pct(b, fe);
                PEND_DIGIT: begin
                    hi = hex_val(held_byte);
                    lo = hex_val(b);
                    v  = 8'(hi * 16 + lo);
                    if (hi < 16 && lo < 16 && is_esc(v)) begin
                        put(v);
                        held_cnt = PEND_NONE;
                    end else begin
                        put(CH_PCT);
                        if (held_byte == CH_PCT) begin
                            after_pct(b, fe);
                        end else begin
                            put(held_byte);
                            fresh(b, fe);
                        end
                    end
                end
                default: fresh(b, fe);
            endcase
            if (fe) held_cnt = PEND_NONE;
        end
        if (step_q.size() != 0) begin
            r = step_q.pop_back();
            r.run_last      = 1'b1;
            r.out_field_end = fe;
            step_q.insert(step_q.size(), r);
        end
    endfunction

    function automatic dir_row_t mk_row(logic m, logic [7:0] b, logic fe, logic [1:0] n,
                                        logic [7:0] t0, logic [7:0] t1, logic [7:0] t2);
        dir_row_t row;
        row.mode    = m;
        row.b       = b;
        row.fe      = fe;
        row.n_typed = n;
        row.t0      = t0;
        row.t1      = t1;
        row.t2      = t2;
        return row;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 10) return CH_DIG0 + 8'(n);
        return ($urandom_range(0, 1) ? CH_UPA : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] pick_esc();
        case ($urandom_range(0, 3))
            0: return CH_PCT;
            1: return CH_BAR;
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // decode fields mix well-formed escapes with truncated escapes, stray '%' and raw bytes
    function automatic void build_field(logic m);
        int         kind;
        logic [7:0] v;
        field_bytes.delete();
        repeat (m ? $urandom_range(1, 4) : $urandom_range(1, 6)) begin
            kind = $urandom_range(0, 9);
            if (!m) begin
                if (kind < 4) field_bytes.insert(field_bytes.size(), pick_esc());
                else field_bytes.insert(field_bytes.size(), 8'($urandom_range(0, 255)));
            end else if (kind < 4) begin
                v = pick_esc();
                field_bytes.insert(field_bytes.size(), CH_PCT);
                field_bytes.insert(field_bytes.size(), hex_char(v[7:4]));
                field_bytes.insert(field_bytes.size(), hex_char(v[3:0]));
            end else if (kind == 4) begin
                field_bytes.insert(field_bytes.size(), CH_PCT);
                field_bytes.insert(field_bytes.size(), hex_char(4'($urandom_range(0, 15))));
                field_bytes.insert(field_bytes.size(), hex_char(4'($urandom_range(0, 15))));
            end else if (kind == 5) begin
                field_bytes.insert(field_bytes.size(), CH_PCT);
                field_bytes.insert(field_bytes.size(), hex_char(4'($urandom_range(0, 15))));
            end else if (kind == 6) begin
                field_bytes.insert(field_bytes.size(), CH_PCT);
                field_bytes.insert(field_bytes.size(), 8'($urandom_range(0, 255)));
            end else if (kind == 7) begin
                field_bytes.insert(field_bytes.size(), CH_PCT);
            end else begin
                field_bytes.insert(field_bytes.size(), 8'($urandom_range(0, 255)));
            end
        end
    endfunction

    task automatic send(dir_row_t row);
        int        gap;
        t_out_item r;
        gap = tx_idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= {row.b, row.fe};
        do @(posedge i_clk); while (full);
        bytes_in++;
        codec_step(row.b, row.fe);
        if (row.n_typed != 0) begin
            step_q.delete();
            for (int i = 0; i < row.n_typed; i++) begin
                r.out_byte      = (i == 0) ? row.t0 : (i == 1) ? row.t1 : row.t2;
                r.run_last      = (i == row.n_typed - 1);
                r.out_field_end = r.run_last && row.fe;
                step_q.insert(step_q.size(), r);
            end
        end
        foreach (step_q[i]) out_bytes_due.insert(out_bytes_due.size(), step_q[i]);
    endtask

    // bytes held in decode make no result, so allow the pipe to settle
    task automatic drain();
        push <= 1'b0;
        while (out_bytes_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_mode(logic m);
        drain();
        i_cfg_we          <= 1'b1;
        i_cfg_decode_mode <= m;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        cur_mode  = m;
        held_cnt  = PEND_NONE;
        held_byte = 8'h00;
        mode_writes++;
    endtask

    function automatic void report(string what, int want, int got);
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    endfunction

    initial begin
        dir_row_t rows[$];
        bit       paused;
        int       n;
        push              <= 1'b0;
        i_in_item         <= '0;
        i_cfg_we          <= 1'b0;
        i_cfg_decode_mode <= 1'b0;
        i_rst_n           <= 1'b0;
        cur_mode   = 1'b0;
        held_cnt   = PEND_NONE;
        held_byte  = 8'h00;
        tx_idle_on = 1'b1;
        paused     = 1'b0;

        // encode from reset: extremes and all four escapes
        rows.insert(rows.size(), mk_row(0, 8'h00, 0, 1, 8'h00, 0, 0));
        rows.insert(rows.size(), mk_row(0, 8'hFF, 0, 1, 8'hFF, 0, 0));
        rows.insert(rows.size(), mk_row(0, CH_PCT, 0, 3, CH_PCT, CH_DIG2, CH_DIG5));
        rows.insert(rows.size(), mk_row(0, CH_BAR, 0, 3, CH_PCT, CH_DIG7, CH_UPC));
        rows.insert(rows.size(), mk_row(0, CH_CR, 0, 3, CH_PCT, CH_DIG0, CH_UPD));
        rows.insert(rows.size(), mk_row(0, CH_LF, 1, 3, CH_PCT, CH_DIG0, CH_UPA));
        // decode: lower-case escape closing a field, then an upper-case one
        rows.insert(rows.size(), mk_row(1, CH_PCT, 0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_row(1, CH_DIG7, 0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_row(1, "c", 1, 1, CH_BAR, 0, 0));
        rows.insert(rows.size(), mk_row(1, CH_PCT, 0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_row(1, CH_DIG0, 0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_row(1, CH_UPD, 0, 1, CH_CR, 0, 0));
        // valid hex, not an escapable value
        rows.insert(rows.size(), mk_row(1, CH_PCT, 0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_row(1, "4", 0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_row(1, "1", 0, 0, 0, 0, 0));
        // held '%' followed by another '%' restarts the escape
        rows.insert(rows.size(), mk_row(1, CH_PCT, 0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_row(1, CH_PCT, 0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_row(1, CH_DIG2, 0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_row(1, CH_DIG5, 0, 0, 0, 0, 0));
        // '%' in the last two positions stays raw
        rows.insert(rows.size(), mk_row(1, CH_PCT, 1, 1, CH_PCT, 0, 0));
        rows.insert(rows.size(), mk_row(1, CH_PCT, 0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_row(1, "4", 1, 2, CH_PCT, "4", 0));
        rows.insert(rows.size(), mk_row(1, 8'hFF, 0, 1, 8'hFF, 0, 0));
        rows.insert(rows.size(), mk_row(1, CH_PCT, 0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_row(1, "Z", 1, 2, CH_PCT, "Z", 0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            if (rows[k].mode != cur_mode) set_mode(rows[k].mode);
            send(rows[k]);
        end

        for (int p = 0; p < 6; p++) begin
            set_mode(PHASE_MODES[p]);
            n = 0;
            while (n < PHASE_ITEMS) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                build_field(cur_mode);
                foreach (field_bytes[j])
                    send(mk_row(cur_mode, field_bytes[j], j == field_bytes.size() - 1,
                                0, 0, 0, 0));
                n += field_bytes.size();
                if (!cur_mode && !paused) begin
                    paused = 1'b1;
                    drain();
                end
            end
        end

        drain();
        $display("Covered %0d bytes in, %0d results out, %0d mode writes in both modes;",
                 bytes_in, results_out, mode_writes);
        $display("input held off by full for %0d cycles.", full_cycles);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        t_out_item got;
        t_out_item want;
        int        gap;
        pop        <= 1'b0;
        rx_idle_on = 1'b1;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!long_stall_done && results_out >= 50 && push) begin
                // long hold-off so the block backs up into full
                long_stall_done = 1'b1;
                pop <= 1'b0;
                repeat (60) @(posedge i_clk);
            end else begin
                if (results_out % 16 == 0) rx_idle_on = ($urandom_range(0, 2) != 0);
                gap = rx_idle_on ? $urandom_range(0, 6) : 0;
                if (gap > 0) begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            got = o_out_item;
            results_out++;
            if (out_bytes_due.size() == 0) begin
                report("unexpected transfer", 0, int'(got.out_byte));
            end else begin
                want = out_bytes_due.pop_front();
                if (got.out_byte !== want.out_byte)
                    report("out_byte", want.out_byte, got.out_byte);
                if (got.out_field_end !== want.out_field_end)
                    report("out_field_end", want.out_field_end, got.out_field_end);
                if (got.run_last !== want.run_last)
                    report("run_last", want.run_last, got.run_last);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
            if (push && full) full_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, out_bytes_due.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule
